// ===== sv/sgec_pkg.sv =====
// Shared types, codes and reset values of the split-grade exposure controller.
package sgec_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HALF_SECONDS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD_MS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_PIN_FIRST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_PIN_SECOND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_MIN_PIXELS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_MAX_PIXELS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEDUPE_WINDOW_MS = 3'd6;

  localparam logic [15:0] RST_MAX_HALF_SECONDS = 16'd1200;
  localparam logic [15:0] RST_TICK_PERIOD_MS   = 16'd500;
  localparam logic [5:0]  RST_LED_PIN_FIRST    = 6'd0;
  localparam logic [5:0]  RST_LED_PIN_SECOND   = 6'd1;
  localparam logic [15:0] RST_LED_MIN_PIXELS   = 16'd1;
  localparam logic [15:0] RST_LED_MAX_PIXELS   = 16'd1024;
  localparam logic [15:0] RST_DEDUPE_WINDOW_MS = 16'd500;

  localparam logic [3:0] REQ_TIME_CHECK  = 4'd0;
  localparam logic [3:0] REQ_FOCUS       = 4'd1;
  localparam logic [3:0] REQ_METER_BLUE  = 4'd2;
  localparam logic [3:0] REQ_METER_GREEN = 4'd3;
  localparam logic [3:0] REQ_HARD        = 4'd4;
  localparam logic [3:0] REQ_SOFT        = 4'd5;
  localparam logic [3:0] REQ_SPLIT       = 4'd6;
  localparam logic [3:0] REQ_STOP        = 4'd7;
  localparam logic [3:0] REQ_LED_CONFIG  = 4'd8;

  localparam logic [2:0] RUN_IDLE        = 3'd0;
  localparam logic [2:0] RUN_FOCUS       = 3'd1;
  localparam logic [2:0] RUN_METER_BLUE  = 3'd2;
  localparam logic [2:0] RUN_METER_GREEN = 3'd3;
  localparam logic [2:0] RUN_HARD        = 3'd4;
  localparam logic [2:0] RUN_SOFT        = 3'd5;
  localparam logic [2:0] RUN_SPLIT_HARD  = 3'd6;
  localparam logic [2:0] RUN_SPLIT_SOFT  = 3'd7;

  typedef enum logic [7:0] {
    M_IDLE        = 8'b0000_0001,
    M_FOCUS       = 8'b0000_0010,
    M_METER_BLUE  = 8'b0000_0100,
    M_METER_GREEN = 8'b0000_1000,
    M_HARD        = 8'b0001_0000,
    M_SOFT        = 8'b0010_0000,
    M_SPLIT_HARD  = 8'b0100_0000,
    M_SPLIT_SOFT  = 8'b1000_0000
  } mode_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    unique case (m)
      M_IDLE:        c = RUN_IDLE;
      M_FOCUS:       c = RUN_FOCUS;
      M_METER_BLUE:  c = RUN_METER_BLUE;
      M_METER_GREEN: c = RUN_METER_GREEN;
      M_HARD:        c = RUN_HARD;
      M_SOFT:        c = RUN_SOFT;
      M_SPLIT_HARD:  c = RUN_SPLIT_HARD;
      M_SPLIT_SOFT:  c = RUN_SPLIT_SOFT;
      default:       c = RUN_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/sgec_in_if.sv =====
// Command and time-check channel of the split-grade exposure controller.
interface sgec_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [15:0] arg_first;
  logic [15:0] arg_second;
  logic [31:0] now_ms;

  modport source (output valid, req_type, arg_first, arg_second, now_ms, input ready);
  modport sink (input valid, req_type, arg_first, arg_second, now_ms, output ready);
endinterface

// ===== sv/sgec_out_if.sv =====
// Result channel of the split-grade exposure controller.
interface sgec_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  run_mode;
  logic [15:0] remaining_half_seconds;
  logic [15:0] pending_soft_half_seconds;
  logic        led_config_accepted;
  logic [15:0] led_pixel_count;
  logic [5:0]  led_pin;

  modport source (output valid, run_mode, remaining_half_seconds, pending_soft_half_seconds,
                  led_config_accepted, led_pixel_count, led_pin, input ready);
  modport sink (input valid, run_mode, remaining_half_seconds, pending_soft_half_seconds,
                led_config_accepted, led_pixel_count, led_pin, output ready);
endinterface

// ===== sv/split_grade_exposure_controller.sv =====
// Top level of the split-grade exposure controller: mode, countdown and LED configuration.
//
//   channel | direction | handshake          | carries
//   in_if   | in        | valid/ready        | req_type, arg_first, arg_second, now_ms
//   out_if  | out       | valid/ready        | mode, counts, LED configuration result
//   cfg_*   | in        | cfg_we, no wait    | seven settings by index
//
// Each transfer is captured in an input register and then processed into the result
// register, so one item per cycle is sustained while the output is taken.
// The state update is a single compare-and-update pass through the state registers.
// The result register frees when it is taken or empty; a stalled output holds the result
// and the input register, and the input is then not ready. Reset is synchronous.
module split_grade_exposure_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  sgec_in_if.sink                          in_if,
  sgec_out_if.source                       out_if,
  input  logic                             cfg_we,
  input  logic [sgec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sgec_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [15:0] max_half_r, tick_period_r, led_min_r, led_max_r, dedupe_r;
  logic [5:0]  pin_first_r, pin_second_r;

  logic        stg_valid_r;
  logic [3:0]  stg_req_r;
  logic [15:0] stg_a_r, stg_b_r;
  logic [31:0] stg_now_r;

  sgec_pkg::mode_t mode_r, mode_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] soft_r, soft_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [15:0] led_cnt_r, led_cnt_nxt;
  logic [5:0]  led_pin_r, led_pin_nxt;
  logic [31:0] led_time_r, led_time_nxt;
  logic        led_valid_r, led_valid_nxt;
  logic        led_acc_nxt;

  logic        out_valid_r;
  logic [2:0]  out_mode_r;
  logic [15:0] out_rem_r, out_soft_r, out_cnt_r;
  logic        out_acc_r;
  logic [5:0]  out_pin_r;

  logic proc_fire, in_fire;
  logic untimed_busy, timed, tick_due, a_ok, b_ok, pin_ok, count_ok, repeat_hit;
  logic [31:0] tick_diff, led_age, enter_tick;
  logic [15:0] rem_dec;

  assign proc_fire = stg_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !stg_valid_r || proc_fire;
  assign in_fire = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_half_r    <= sgec_pkg::RST_MAX_HALF_SECONDS;
      tick_period_r <= sgec_pkg::RST_TICK_PERIOD_MS;
      pin_first_r   <= sgec_pkg::RST_LED_PIN_FIRST;
      pin_second_r  <= sgec_pkg::RST_LED_PIN_SECOND;
      led_min_r     <= sgec_pkg::RST_LED_MIN_PIXELS;
      led_max_r     <= sgec_pkg::RST_LED_MAX_PIXELS;
      dedupe_r      <= sgec_pkg::RST_DEDUPE_WINDOW_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgec_pkg::CFG_MAX_HALF_SECONDS: max_half_r    <= cfg_wdata;
        sgec_pkg::CFG_TICK_PERIOD_MS:   tick_period_r <= cfg_wdata;
        sgec_pkg::CFG_LED_PIN_FIRST:    pin_first_r   <= cfg_wdata[5:0];
        sgec_pkg::CFG_LED_PIN_SECOND:   pin_second_r  <= cfg_wdata[5:0];
        sgec_pkg::CFG_LED_MIN_PIXELS:   led_min_r     <= cfg_wdata;
        sgec_pkg::CFG_LED_MAX_PIXELS:   led_max_r     <= cfg_wdata;
        sgec_pkg::CFG_DEDUPE_WINDOW_MS: dedupe_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      stg_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_req_r <= in_if.req_type;
      stg_a_r   <= in_if.arg_first;
      stg_b_r   <= in_if.arg_second;
      stg_now_r <= in_if.now_ms;
    end
  end

  assign untimed_busy = (mode_r == sgec_pkg::M_FOCUS) || (mode_r == sgec_pkg::M_METER_BLUE) ||
                        (mode_r == sgec_pkg::M_METER_GREEN);
  assign timed = (mode_r == sgec_pkg::M_HARD) || (mode_r == sgec_pkg::M_SOFT) ||
                 (mode_r == sgec_pkg::M_SPLIT_HARD) || (mode_r == sgec_pkg::M_SPLIT_SOFT);
  assign tick_diff = stg_now_r - tick_r;
  assign tick_due = timed && !tick_diff[31];
  assign rem_dec = (rem_r != 16'd0) ? rem_r - 16'd1 : 16'd0;
  assign enter_tick = stg_now_r + {16'd0, tick_period_r};
  assign a_ok = (stg_a_r != 16'd0) && (stg_a_r <= max_half_r);
  assign b_ok = (stg_b_r != 16'd0) && (stg_b_r <= max_half_r);
  assign pin_ok = (stg_b_r == {10'd0, pin_first_r}) || (stg_b_r == {10'd0, pin_second_r});
  assign count_ok = (stg_a_r >= led_min_r) && (stg_a_r <= led_max_r);
  assign led_age = stg_now_r - led_time_r;
  assign repeat_hit = led_valid_r && (stg_a_r == led_cnt_r) &&
                      (stg_b_r == {10'd0, led_pin_r}) && (led_age < {16'd0, dedupe_r});

  always_comb begin
    mode_nxt      = mode_r;
    rem_nxt       = rem_r;
    soft_nxt      = soft_r;
    tick_nxt      = tick_r;
    led_cnt_nxt   = led_cnt_r;
    led_pin_nxt   = led_pin_r;
    led_time_nxt  = led_time_r;
    led_valid_nxt = led_valid_r;
    led_acc_nxt   = 1'b0;
    unique case (stg_req_r)
      sgec_pkg::REQ_TIME_CHECK: begin
        if (tick_due) begin
          tick_nxt = tick_r + {16'd0, tick_period_r};
          rem_nxt  = rem_dec;
          if (rem_dec == 16'd0) begin
            if ((mode_r == sgec_pkg::M_SPLIT_HARD) && (soft_r != 16'd0)) begin
              mode_nxt = sgec_pkg::M_SPLIT_SOFT;
              rem_nxt  = soft_r;
              soft_nxt = 16'd0;
            end else begin
              mode_nxt = sgec_pkg::M_IDLE;
            end
          end
        end
      end
      sgec_pkg::REQ_FOCUS: begin
        if ((mode_r == sgec_pkg::M_IDLE) || (mode_r == sgec_pkg::M_FOCUS)) begin
          mode_nxt = sgec_pkg::M_FOCUS;
          rem_nxt  = 16'd0;
          soft_nxt = 16'd0;
          tick_nxt = enter_tick;
        end
      end
      sgec_pkg::REQ_METER_BLUE, sgec_pkg::REQ_METER_GREEN: begin
        if ((mode_r == sgec_pkg::M_IDLE) || (mode_r == sgec_pkg::M_METER_BLUE) ||
            (mode_r == sgec_pkg::M_METER_GREEN)) begin
          mode_nxt = (stg_req_r == sgec_pkg::REQ_METER_BLUE) ? sgec_pkg::M_METER_BLUE
                                                              : sgec_pkg::M_METER_GREEN;
          rem_nxt  = 16'd0;
          soft_nxt = 16'd0;
          tick_nxt = enter_tick;
        end
      end
      sgec_pkg::REQ_HARD, sgec_pkg::REQ_SOFT: begin
        if (!untimed_busy && a_ok) begin
          mode_nxt = (stg_req_r == sgec_pkg::REQ_HARD) ? sgec_pkg::M_HARD : sgec_pkg::M_SOFT;
          rem_nxt  = stg_a_r;
          soft_nxt = 16'd0;
          tick_nxt = enter_tick;
        end
      end
      sgec_pkg::REQ_SPLIT: begin
        if (!untimed_busy && a_ok && b_ok) begin
          mode_nxt = sgec_pkg::M_SPLIT_HARD;
          rem_nxt  = stg_a_r;
          soft_nxt = stg_b_r;
          tick_nxt = enter_tick;
        end
      end
      sgec_pkg::REQ_STOP: begin
        mode_nxt = sgec_pkg::M_IDLE;
        rem_nxt  = 16'd0;
        soft_nxt = 16'd0;
        tick_nxt = enter_tick;
      end
      sgec_pkg::REQ_LED_CONFIG: begin
        if ((mode_r == sgec_pkg::M_IDLE) && pin_ok && count_ok && !repeat_hit) begin
          led_cnt_nxt   = stg_a_r;
          led_pin_nxt   = stg_b_r[5:0];
          led_time_nxt  = stg_now_r;
          led_valid_nxt = 1'b1;
          led_acc_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= sgec_pkg::M_IDLE;
      rem_r       <= 16'd0;
      soft_r      <= 16'd0;
      tick_r      <= 32'd0;
      led_cnt_r   <= 16'd0;
      led_pin_r   <= 6'd0;
      led_time_r  <= 32'd0;
      led_valid_r <= 1'b0;
    end else if (proc_fire) begin
      mode_r      <= mode_nxt;
      rem_r       <= rem_nxt;
      soft_r      <= soft_nxt;
      tick_r      <= tick_nxt;
      led_cnt_r   <= led_cnt_nxt;
      led_pin_r   <= led_pin_nxt;
      led_time_r  <= led_time_nxt;
      led_valid_r <= led_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_mode_r <= sgec_pkg::mode_code(mode_nxt);
      out_rem_r  <= rem_nxt;
      out_soft_r <= soft_nxt;
      out_acc_r  <= led_acc_nxt;
      out_cnt_r  <= led_cnt_nxt;
      out_pin_r  <= led_pin_nxt;
    end
  end

  assign out_if.valid                     = out_valid_r;
  assign out_if.run_mode                  = out_mode_r;
  assign out_if.remaining_half_seconds    = out_rem_r;
  assign out_if.pending_soft_half_seconds = out_soft_r;
  assign out_if.led_config_accepted       = out_acc_r;
  assign out_if.led_pixel_count           = out_cnt_r;
  assign out_if.led_pin                   = out_pin_r;

endmodule

// ===== sv/sgec_checker.sv =====
// Port-level assertions for the split-grade exposure controller and their binding.
module sgec_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  run_mode,
  input logic [15:0] remaining_half_seconds,
  input logic [15:0] pending_soft_half_seconds,
  input logic        led_config_accepted
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(run_mode) &&
      $stable(remaining_half_seconds) && $stable(pending_soft_half_seconds))
    else $error("Stalled result changed or was dropped.");

  // Only a timed mode can hold a countdown.
  a_untimed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (run_mode == sgec_pkg::RUN_IDLE || run_mode == sgec_pkg::RUN_FOCUS ||
      run_mode == sgec_pkg::RUN_METER_BLUE || run_mode == sgec_pkg::RUN_METER_GREEN)
      |-> remaining_half_seconds == 16'd0)
    else $error("Countdown left in an untimed mode.");

  // Soft time waits only during the hard phase of a split grade; an LED change only in idle.
  a_soft_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && run_mode != sgec_pkg::RUN_SPLIT_HARD && run_mode != sgec_pkg::RUN_IDLE
      |-> pending_soft_half_seconds == 16'd0)
    else $error("Soft time pending outside split grade.");

  a_led_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && led_config_accepted |-> run_mode == sgec_pkg::RUN_IDLE)
    else $error("LED configuration accepted outside idle.");

endmodule

bind split_grade_exposure_controller sgec_checker u_sgec_checker (
  .clk                       (clk),
  .rst_n                     (rst_n),
  .out_valid                 (out_if.valid),
  .out_ready                 (out_if.ready),
  .run_mode                  (out_if.run_mode),
  .remaining_half_seconds    (out_if.remaining_half_seconds),
  .pending_soft_half_seconds (out_if.pending_soft_half_seconds),
  .led_config_accepted       (out_if.led_config_accepted)
);

// ===== verif/tb_split_grade_exposure_controller.sv =====
// Self-checking testbench for the split-grade exposure controller, with its own scoreboard model.
module tb_split_grade_exposure_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] REQ_UNUSED_FIRST = 4'd9;
  localparam logic [3:0] REQ_UNUSED_LAST  = 4'd15;
  localparam int unsigned MAX_GAP = 17;
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned PHASE_COUNT = 6;
  localparam int unsigned ITEMS_PER_PHASE = 320;

  typedef struct {
    logic [3:0]  req;
    logic [15:0] first;
    logic [15:0] second;
    logic [31:0] stamp;
  } command_t;

  typedef struct {
    logic [2:0]  run_mode;
    logic [15:0] remaining;
    logic [15:0] pending_soft;
    logic        led_accepted;
    logic [15:0] pixels;
    logic [5:0]  pin;
  } status_t;

  typedef struct {
    logic [15:0] max_half;
    logic [15:0] tick_period;
    logic [5:0]  pin_first;
    logic [5:0]  pin_second;
    logic [15:0] min_pixels;
    logic [15:0] max_pixels;
    logic [15:0] window;
  } settings_t;

  class exposure_scoreboard;
    logic [15:0] max_half, tick_period, min_pixels, max_pixels, window;
    logic [5:0]  pin_first, pin_second;
    logic [2:0]  mode;
    logic [15:0] remaining, soft_wait, led_count;
    logic [31:0] next_tick, led_stamp;
    logic [5:0]  led_pin;
    bit          led_valid;
    status_t     expected_q[$];
    int          errors;
    int          results_seen;

    function new();
      max_half = sgec_pkg::RST_MAX_HALF_SECONDS;
      tick_period = sgec_pkg::RST_TICK_PERIOD_MS;
      pin_first = sgec_pkg::RST_LED_PIN_FIRST;
      pin_second = sgec_pkg::RST_LED_PIN_SECOND;
      min_pixels = sgec_pkg::RST_LED_MIN_PIXELS;
      max_pixels = sgec_pkg::RST_LED_MAX_PIXELS;
      window = sgec_pkg::RST_DEDUPE_WINDOW_MS;
      mode = sgec_pkg::RUN_IDLE;
      remaining = '0;
      soft_wait = '0;
      next_tick = '0;
      led_count = '0;
      led_pin = '0;
      led_stamp = '0;
      led_valid = 1'b0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void set_register(logic [sgec_pkg::CFG_IDX_W-1:0] idx,
                               logic [sgec_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sgec_pkg::CFG_MAX_HALF_SECONDS: max_half = data;
        sgec_pkg::CFG_TICK_PERIOD_MS:   tick_period = data;
        sgec_pkg::CFG_LED_PIN_FIRST:    pin_first = data[5:0];
        sgec_pkg::CFG_LED_PIN_SECOND:   pin_second = data[5:0];
        sgec_pkg::CFG_LED_MIN_PIXELS:   min_pixels = data;
        sgec_pkg::CFG_LED_MAX_PIXELS:   max_pixels = data;
        sgec_pkg::CFG_DEDUPE_WINDOW_MS: window = data;
        default: ;
      endcase
    endfunction

    function bit busy_untimed();
      return mode == sgec_pkg::RUN_FOCUS || mode == sgec_pkg::RUN_METER_BLUE ||
             mode == sgec_pkg::RUN_METER_GREEN;
    endfunction

    function bit length_ok(logic [15:0] v);
      return v != 16'd0 && v <= max_half;
    endfunction

    function void start_mode(logic [2:0] m, logic [15:0] len, logic [15:0] rest,
                             logic [31:0] stamp);
      mode = m;
      remaining = len;
      soft_wait = rest;
      next_tick = stamp + {16'd0, tick_period};
    endfunction

    // A tick is due once the stamp is not before the next tick time, wrap-safe.
    function void step_clock(logic [31:0] stamp);
      logic [31:0] lag;
      if (mode == sgec_pkg::RUN_IDLE || busy_untimed()) return;
      lag = stamp - next_tick;
      if (lag[31]) return;
      next_tick = next_tick + {16'd0, tick_period};
      if (remaining != 16'd0) remaining = remaining - 16'd1;
      if (remaining != 16'd0) return;
      if (mode == sgec_pkg::RUN_SPLIT_HARD && soft_wait != 16'd0) begin
        mode = sgec_pkg::RUN_SPLIT_SOFT;
        remaining = soft_wait;
        soft_wait = '0;
      end else begin
        mode = sgec_pkg::RUN_IDLE;
      end
    endfunction

    function void note_input(command_t c);
      status_t s;
      logic [31:0] lag;
      bit taken, pin_ok, count_ok, repeat_hit;
      taken = 1'b0;
      case (c.req)
        sgec_pkg::REQ_TIME_CHECK: step_clock(c.stamp);
        sgec_pkg::REQ_FOCUS:
          if (mode == sgec_pkg::RUN_IDLE || mode == sgec_pkg::RUN_FOCUS)
            start_mode(sgec_pkg::RUN_FOCUS, '0, '0, c.stamp);
        sgec_pkg::REQ_METER_BLUE, sgec_pkg::REQ_METER_GREEN:
          if (mode == sgec_pkg::RUN_IDLE || mode == sgec_pkg::RUN_METER_BLUE ||
              mode == sgec_pkg::RUN_METER_GREEN)
            start_mode((c.req == sgec_pkg::REQ_METER_BLUE) ? sgec_pkg::RUN_METER_BLUE
                                                           : sgec_pkg::RUN_METER_GREEN,
                       '0, '0, c.stamp);
        sgec_pkg::REQ_HARD, sgec_pkg::REQ_SOFT:
          if (!busy_untimed() && length_ok(c.first))
            start_mode((c.req == sgec_pkg::REQ_HARD) ? sgec_pkg::RUN_HARD : sgec_pkg::RUN_SOFT,
                       c.first, '0, c.stamp);
        sgec_pkg::REQ_SPLIT:
          if (!busy_untimed() && length_ok(c.first) && length_ok(c.second))
            start_mode(sgec_pkg::RUN_SPLIT_HARD, c.first, c.second, c.stamp);
        sgec_pkg::REQ_STOP: start_mode(sgec_pkg::RUN_IDLE, '0, '0, c.stamp);
        sgec_pkg::REQ_LED_CONFIG: begin
          // The pin is compared at full width, so values of 64 and above never match.
          pin_ok = c.second == {10'd0, pin_first} || c.second == {10'd0, pin_second};
          count_ok = c.first >= min_pixels && c.first <= max_pixels;
          lag = c.stamp - led_stamp;
          repeat_hit = led_valid && c.first == led_count && c.second == {10'd0, led_pin} &&
                       lag < {16'd0, window};
          if (mode == sgec_pkg::RUN_IDLE && pin_ok && count_ok && !repeat_hit) begin
            led_count = c.first;
            led_pin = c.second[5:0];
            led_stamp = c.stamp;
            led_valid = 1'b1;
            taken = 1'b1;
          end
        end
        default: ;
      endcase
      s.run_mode = mode;
      s.remaining = remaining;
      s.pending_soft = soft_wait;
      s.led_accepted = taken;
      s.pixels = led_count;
      s.pin = led_pin;
      expected_q.push_back(s);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("ERROR: %s on result %0d: got %0h, expected %0h",
               what, results_seen, got, want);
    endtask

    task check_result(status_t got);
      status_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("result with no command waiting", 32'(got.run_mode), 32'd0);
        return;
      end
      want = expected_q.pop_front();
      if (got.run_mode !== want.run_mode)
        report("run_mode", 32'(got.run_mode), 32'(want.run_mode));
      if (got.remaining !== want.remaining)
        report("remaining_half_seconds", 32'(got.remaining), 32'(want.remaining));
      if (got.pending_soft !== want.pending_soft)
        report("pending_soft_half_seconds", 32'(got.pending_soft), 32'(want.pending_soft));
      if (got.led_accepted !== want.led_accepted)
        report("led_config_accepted", 32'(got.led_accepted), 32'(want.led_accepted));
      if (got.pixels !== want.pixels)
        report("led_pixel_count", 32'(got.pixels), 32'(want.pixels));
      if (got.pin !== want.pin) report("led_pin", 32'(got.pin), 32'(want.pin));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [sgec_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sgec_pkg::CFG_DATA_W-1:0] cfg_wdata;

  sgec_in_if in_if ();
  sgec_out_if out_if ();

  split_grade_exposure_controller DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_if),
    .out_if(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  exposure_scoreboard board = new();
  logic [31:0] clock_ms;
  int unsigned commands_sent;
  int unsigned cycles;
  bit send_burst;
  bit take_burst;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send(logic [3:0] req, logic [15:0] a, logic [15:0] b, logic [31:0] stamp);
    command_t c;
    int unsigned gap;
    c.req = req;
    c.first = a;
    c.second = b;
    c.stamp = stamp;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= req;
    in_if.arg_first <= a;
    in_if.arg_second <= b;
    in_if.now_ms <= stamp;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    board.note_input(c);
    if (req <= sgec_pkg::REQ_LED_CONFIG) commands_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [sgec_pkg::CFG_IDX_W-1:0] idx,
                                logic [sgec_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.set_register(idx, data);
  endtask

  task automatic apply_settings(settings_t s);
    write_register(sgec_pkg::CFG_MAX_HALF_SECONDS, s.max_half);
    write_register(sgec_pkg::CFG_TICK_PERIOD_MS, s.tick_period);
    write_register(sgec_pkg::CFG_LED_PIN_FIRST, {10'd0, s.pin_first});
    write_register(sgec_pkg::CFG_LED_PIN_SECOND, {10'd0, s.pin_second});
    write_register(sgec_pkg::CFG_LED_MIN_PIXELS, s.min_pixels);
    write_register(sgec_pkg::CFG_LED_MAX_PIXELS, s.max_pixels);
    write_register(sgec_pkg::CFG_DEDUPE_WINDOW_MS, s.window);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_length();
    logic [15:0] top;
    top = (board.max_half < 16'd4) ? board.max_half : 16'd4;
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return board.max_half;
      2: return board.max_half + 16'd1;
      3: return 16'($urandom);
      default: return 16'($urandom_range(1, top));
    endcase
  endfunction

  function automatic logic [31:0] tick_advance();
    logic [31:0] p;
    int unsigned pick;
    p = {16'd0, board.tick_period};
    pick = $urandom_range(0, 19);
    if (pick == 0) return $urandom;
    if (pick <= 2) return (p == 0) ? 32'd0 : $urandom_range(0, p - 1);
    if (pick <= 4) return p + $urandom_range(1, 40);
    return p;
  endfunction

  function automatic logic [15:0] pick_pixels();
    case ($urandom_range(0, 6))
      0: return board.min_pixels;
      1: return board.max_pixels;
      2: return board.min_pixels - 16'd1;
      3: return board.max_pixels + 16'd1;
      4: return 16'($urandom);
      5: return board.led_count;
      default:
        if (board.min_pixels <= board.max_pixels)
          return 16'($urandom_range(board.min_pixels, board.max_pixels));
        else
          return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_pin();
    case ($urandom_range(0, 5))
      0: return {10'd0, board.pin_first};
      1: return {10'd0, board.pin_second};
      2: return 16'($urandom_range(0, 63));
      3: return 16'($urandom);
      4: return {10'd0, board.led_pin};
      default: return {10'd0, board.pin_first};
    endcase
  endfunction

  function automatic logic [31:0] led_gap();
    logic [31:0] w;
    w = {16'd0, board.window};
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return (w == 0) ? 32'd0 : w - 1;
      2: return w;
      3: return $urandom;
      default: return $urandom_range(0, 2 * w + 1);
    endcase
  endfunction

  task automatic send_noise();
    logic [31:0] stamp;
    stamp = $urandom_range(0, 1) ? $urandom : clock_ms;
    send(4'($urandom_range(0, 15)), 16'($urandom), 16'($urandom), stamp);
  endtask

  task automatic run_exposure();
    logic [3:0] kind;
    int unsigned steps;
    if (board.mode != sgec_pkg::RUN_IDLE && $urandom_range(0, 1))
      send(sgec_pkg::REQ_STOP, 16'($urandom), 16'($urandom), clock_ms);
    case ($urandom_range(0, 2))
      0: kind = sgec_pkg::REQ_HARD;
      1: kind = sgec_pkg::REQ_SOFT;
      default: kind = sgec_pkg::REQ_SPLIT;
    endcase
    clock_ms += $urandom_range(0, 50);
    send(kind, pick_length(), pick_length(), clock_ms);
    steps = $urandom_range(2, 12);
    repeat (steps) begin
      if ($urandom_range(0, 7) == 0) begin
        send_noise();
      end else begin
        clock_ms += tick_advance();
        send(sgec_pkg::REQ_TIME_CHECK, 16'($urandom), 16'($urandom), clock_ms);
      end
    end
  endtask

  task automatic run_led();
    int unsigned count;
    if (board.mode != sgec_pkg::RUN_IDLE && $urandom_range(0, 3) != 0)
      send(sgec_pkg::REQ_STOP, 16'($urandom), 16'($urandom), clock_ms);
    count = $urandom_range(2, 8);
    repeat (count) begin
      clock_ms += led_gap();
      send(sgec_pkg::REQ_LED_CONFIG, pick_pixels(), pick_pin(), clock_ms);
    end
  endtask

  task automatic run_metering();
    int unsigned count;
    logic [3:0] req;
    send(4'($urandom_range(sgec_pkg::REQ_FOCUS, sgec_pkg::REQ_METER_GREEN)),
         16'($urandom), 16'($urandom), clock_ms);
    count = $urandom_range(2, 6);
    repeat (count) begin
      clock_ms += tick_advance();
      case ($urandom_range(0, 6))
        0: req = sgec_pkg::REQ_FOCUS;
        1: req = sgec_pkg::REQ_METER_BLUE;
        2: req = sgec_pkg::REQ_METER_GREEN;
        3: req = sgec_pkg::REQ_HARD;
        4: req = sgec_pkg::REQ_SPLIT;
        5: req = sgec_pkg::REQ_LED_CONFIG;
        default: req = sgec_pkg::REQ_TIME_CHECK;
      endcase
      send(req, pick_length(), pick_length(), clock_ms);
    end
    if ($urandom_range(0, 3) != 0)
      send(sgec_pkg::REQ_STOP, 16'($urandom), 16'($urandom), clock_ms);
  endtask

  task automatic run_directed();
    send(sgec_pkg::REQ_TIME_CHECK, 16'd0, 16'd0, 32'd0);
    send(REQ_UNUSED_LAST, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send(REQ_UNUSED_FIRST, 16'd5, 16'd1, 32'd50);
    send(sgec_pkg::REQ_LED_CONFIG, 16'd1, 16'd0, 32'd100);
    send(sgec_pkg::REQ_LED_CONFIG, 16'd1, 16'd0, 32'd200);
    send(sgec_pkg::REQ_LED_CONFIG, 16'd1, 16'd0, 32'd600);
    send(sgec_pkg::REQ_LED_CONFIG, 16'd5, 16'd64, 32'd700);
    send(sgec_pkg::REQ_LED_CONFIG, 16'd1024, 16'd1, 32'd800);
    send(sgec_pkg::REQ_LED_CONFIG, 16'd1025, 16'd1, 32'd900);
    send(sgec_pkg::REQ_FOCUS, 16'd0, 16'd0, 32'd1100);
    send(sgec_pkg::REQ_LED_CONFIG, 16'd2, 16'd0, 32'd1200);
    send(sgec_pkg::REQ_HARD, 16'd3, 16'd0, 32'd1300);
    send(sgec_pkg::REQ_METER_BLUE, 16'd0, 16'd0, 32'd1350);
    send(sgec_pkg::REQ_STOP, 16'd0, 16'd0, 32'd1380);
    send(sgec_pkg::REQ_METER_BLUE, 16'd0, 16'd0, 32'd1400);
    send(sgec_pkg::REQ_METER_GREEN, 16'd0, 16'd0, 32'd1500);
    send(sgec_pkg::REQ_TIME_CHECK, 16'd0, 16'd0, 32'd5000);
    send(sgec_pkg::REQ_HARD, 16'd0, 16'd0, 32'd5100);
    send(sgec_pkg::REQ_STOP, 16'd0, 16'd0, 32'd5200);
    send(sgec_pkg::REQ_HARD, 16'd1201, 16'd0, 32'd5300);
    send(sgec_pkg::REQ_SPLIT, 16'd1200, 16'd0, 32'd5400);
    send(sgec_pkg::REQ_SPLIT, 16'd2, 16'd1, 32'd6000);
    send(sgec_pkg::REQ_TIME_CHECK, 16'd0, 16'd0, 32'd6499);
    send(sgec_pkg::REQ_TIME_CHECK, 16'd0, 16'd0, 32'd6500);
    send(sgec_pkg::REQ_TIME_CHECK, 16'd0, 16'd0, 32'd7000);
    send(sgec_pkg::REQ_TIME_CHECK, 16'd0, 16'd0, 32'd7500);
    send(sgec_pkg::REQ_SOFT, 16'd1, 16'd0, 32'hFFFF_FF00);
    send(sgec_pkg::REQ_TIME_CHECK, 16'd0, 16'd0, 32'hFFFF_FFFF);
    send(sgec_pkg::REQ_TIME_CHECK, 16'd0, 16'd0, 32'h0000_0100);
  endtask

  initial begin
    status_t got;
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = take_burst ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got.run_mode = out_if.run_mode;
      got.remaining = out_if.remaining_half_seconds;
      got.pending_soft = out_if.pending_soft_half_seconds;
      got.led_accepted = out_if.led_config_accepted;
      got.pixels = out_if.led_pixel_count;
      got.pin = out_if.led_pin;
      board.check_result(got);
    end
  end

  initial begin
    settings_t plan;
    int unsigned goal;
    int unsigned settle;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_if.valid <= 1'b0;
    in_if.req_type <= '0;
    in_if.arg_first <= '0;
    in_if.arg_second <= '0;
    in_if.now_ms <= '0;
    commands_sent = 0;
    send_burst = 1'b0;
    take_burst = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    clock_ms = 32'h0001_0000;
    goal = commands_sent;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase != 0) begin
        drain();
        case (phase)
          1: plan = '{16'hFFFF, 16'd1, 6'd63, 6'd62, 16'd0, 16'hFFFF, 16'd0};
          2: plan = '{16'd1, 16'hFFFF, 6'd0, 6'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF};
          3: plan = '{16'd8, 16'd0, 6'd5, 6'd40, 16'd3, 16'd12, 16'd20};
          4: plan = '{16'($urandom_range(1, 16)), 16'($urandom_range(1, 40)),
                      6'($urandom), 6'($urandom), 16'($urandom_range(0, 20)),
                      16'($urandom_range(10, 300)), 16'($urandom_range(0, 100))};
          default: plan = '{sgec_pkg::RST_MAX_HALF_SECONDS, sgec_pkg::RST_TICK_PERIOD_MS,
                            sgec_pkg::RST_LED_PIN_FIRST, sgec_pkg::RST_LED_PIN_SECOND,
                            sgec_pkg::RST_LED_MIN_PIXELS, sgec_pkg::RST_LED_MAX_PIXELS,
                            sgec_pkg::RST_DEDUPE_WINDOW_MS};
        endcase
        apply_settings(plan);
        @(posedge clk);
        if ($urandom_range(0, 1)) clock_ms = $urandom;
      end
      goal += ITEMS_PER_PHASE;
      while (commands_sent < goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: run_exposure();
          5, 6: run_led();
          7: run_metering();
          default: repeat ($urandom_range(1, 3)) send_noise();
        endcase
      end
    end

    in_if.valid <= 1'b0;
    settle = 0;
    while (board.expected_q.size() != 0 && settle < 5000) begin
      @(posedge clk);
      settle++;
    end
    repeat (10) @(posedge clk);
    while (board.expected_q.size() != 0) begin
      void'(board.expected_q.pop_front());
      board.report("result never arrived", 32'd0, 32'd0);
    end
    if (board.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
